>>> rtl/core/htbd_pkg.sv
// Shared types and constants for the Huffman tree-walk bit decoder.
// No dependencies; imported by every module of the block.
package htbd_pkg;

  localparam int NODE_W      = 9;    // node index: leaves 0..255, internal 256..511
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 8;
  localparam int BIT_IDX_W   = 3;
  localparam int STORE_AW    = 8;    // node store holds internal nodes only
  localparam int ENTRY_W     = 20;   // {r_present, r_child, l_present, l_child}
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int Q_DEPTH     = 2;

  // Node store entry layout
  localparam int L_CHILD_LSB = 0;
  localparam int L_PRES_BIT  = 9;
  localparam int R_CHILD_LSB = 10;
  localparam int R_PRES_BIT  = 19;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TOTAL = 1'b1;

  typedef enum logic {
    OP_NODE,
    OP_CODE
  } item_op_t;

  // Classified item as it travels through the queue.
  // For OP_CODE the code byte sits in data[CODE_W-1:0].
  typedef struct packed {
    item_op_t              op;
    logic [STORE_AW-1:0]   addr;
    logic [ENTRY_W-1:0]    data;
  } q_item_t;

  // Configuration as seen by the walker
  typedef struct packed {
    logic                root_wr;
    logic [NODE_W-1:0]   root_wdata;
    logic [NODE_W-1:0]   root;
    logic [CNT_W-1:0]    total;
  } cfg_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_FLUSH
  } bk_state_t;

endpackage

>>> rtl/core/huffman_tree_bit_decoder_unit.sv
// Huffman tree-walk bit decoder, top level: config registers, front end,
// item queue and tree walker. Depends on htbd_pkg, htbd_front, htbd_queue, htbd_back.
//
//  - Input: an item transfers on a clock edge with start high and busy low.
//    in_kind 0 writes one internal node (256..511) of the code tree,
//    in_kind 1 hands over one code byte, decoded MSB first.
//  - Results: out_valid marks each symbol for exactly one cycle; there is
//    no back-pressure. out_last flags the last symbol of a code byte,
//    out_finished the symbol that reaches symbol_total.
//  - Config: cfg_we writes cfg_wdata to register cfg_index (0 = root_node,
//    1 = symbol_total) at once. Writing root_node restarts the walk there.
//    Write config only while the block is idle.
//  - Timing: an item is held in the front register, then waits in a
//    QUEUE_DEPTH-entry queue. The walker takes one tree step per cycle, set by
//    the single registered read port of the node store. A node write is a
//    single store write; a code byte is a pop, up to eight steps and a flush,
//    with an extra store read first after a node write or root change. A
//    symbol waits for the next one or the end of its byte to learn its last flag.
//  - Reset: clears the queue, walker and counter; root_node returns to 256,
//    symbol_total to 0. The node store is not cleared.
module huffman_tree_bit_decoder_unit #(
  parameter int QUEUE_DEPTH = htbd_pkg::Q_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [htbd_pkg::NODE_W-1:0]     in_node_index,
  input  logic [htbd_pkg::NODE_W-1:0]     in_left_child,
  input  logic                            in_left_present,
  input  logic [htbd_pkg::NODE_W-1:0]     in_right_child,
  input  logic                            in_right_present,
  input  logic [htbd_pkg::CODE_W-1:0]     in_code_byte,
  output logic                            out_valid,
  output logic [htbd_pkg::SYM_W-1:0]      out_symbol,
  output logic                            out_last,
  output logic                            out_finished,
  input  logic                            cfg_we,
  input  logic [htbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import htbd_pkg::*;

  logic [NODE_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              root_wr;
  cfg_ctl_t          cfg_ctl;

  logic    q_full, q_push, q_pop, q_valid;
  q_item_t fr_item, q_item;

  // Config registers
  always_comb begin
    root_nxt  = root_r;
    total_nxt = total_r;
    root_wr   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT_NODE: begin
          root_nxt = cfg_wdata[NODE_W-1:0];
          root_wr  = 1'b1;
        end
        CFG_SYMBOL_TOTAL: total_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= NODE_W'(1 << STORE_AW);
      total_r <= '0;
    end else begin
      root_r  <= root_nxt;
      total_r <= total_nxt;
    end
  end

  assign cfg_ctl.root_wr    = root_wr;
  assign cfg_ctl.root_wdata = cfg_wdata[NODE_W-1:0];
  assign cfg_ctl.root       = root_r;
  assign cfg_ctl.total      = total_r;

  htbd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_node_index    (in_node_index),
    .in_left_child    (in_left_child),
    .in_left_present  (in_left_present),
    .in_right_child   (in_right_child),
    .in_right_present (in_right_present),
    .in_code_byte     (in_code_byte),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (fr_item)
  );

  htbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (q_item)
  );

  htbd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .cfg          (cfg_ctl),
    .out_valid    (out_valid),
    .out_symbol   (out_symbol),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

endmodule

>>> rtl/core/htbd_front.sv
// Front end: accepts items, drops invalid node writes, packs queue entries.
// Depends on htbd_pkg.
module htbd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [htbd_pkg::NODE_W-1:0] in_node_index,
  input  logic [htbd_pkg::NODE_W-1:0] in_left_child,
  input  logic                        in_left_present,
  input  logic [htbd_pkg::NODE_W-1:0] in_right_child,
  input  logic                        in_right_present,
  input  logic [htbd_pkg::CODE_W-1:0] in_code_byte,
  input  logic                        q_full,
  output logic                        q_push,
  output htbd_pkg::q_item_t           q_item
);
  import htbd_pkg::*;

  logic     fr_valid_r, fr_valid_nxt;
  q_item_t  fr_item_r, fr_item_nxt;
  logic     accept, keep;

  assign busy   = fr_valid_r & q_full;
  assign accept = start & ~busy;
  assign q_push = fr_valid_r & ~q_full;
  assign q_item = fr_item_r;

  // node writes below the internal range are dropped here
  assign keep = in_kind | in_node_index[NODE_W-1];

  always_comb begin
    fr_item_nxt = fr_item_r;
    if (accept) begin
      if (in_kind) begin
        fr_item_nxt.op   = OP_CODE;
        fr_item_nxt.addr = '0;
        fr_item_nxt.data = {{(ENTRY_W-CODE_W){1'b0}}, in_code_byte};
      end else begin
        fr_item_nxt.op   = OP_NODE;
        fr_item_nxt.addr = in_node_index[STORE_AW-1:0];
        fr_item_nxt.data = {in_right_present, in_right_child, in_left_present, in_left_child};
      end
    end
  end

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (q_push) fr_valid_nxt = 1'b0;
    if (accept && keep) fr_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

endmodule

>>> rtl/core/htbd_queue.sv
// Small FIFO between the front end and the tree walker.
// Depends on htbd_pkg.
module htbd_queue #(
  parameter int DEPTH = htbd_pkg::Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  htbd_pkg::q_item_t  push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output htbd_pkg::q_item_t  pop_item
);
  import htbd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  q_item_t              slots_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full      = (count_r == CNT_W_Q'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slots_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_item;
  end

endmodule

>>> rtl/core/htbd_back.sv
// Back end: node store, tree walker, symbol counter and result register.
// Depends on htbd_pkg.
module htbd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  htbd_pkg::q_item_t           q_item,
  output logic                        q_pop,
  input  htbd_pkg::cfg_ctl_t          cfg,
  output logic                        out_valid,
  output logic [htbd_pkg::SYM_W-1:0]  out_symbol,
  output logic                        out_last,
  output logic                        out_finished
);
  import htbd_pkg::*;

  localparam int STORE_DEPTH = 1 << STORE_AW;

  bk_state_t state_r, state_nxt;

  // node store, registered read
  logic [ENTRY_W-1:0]  store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]  rdata_r;
  logic                rd_en, wr_en;
  logic [STORE_AW-1:0] rd_addr, wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic                 rd_ok_r, rd_ok_nxt;    // rdata_r holds the entry of cur_r
  logic [CODE_W-1:0]    code_r, code_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [CNT_W-1:0]     emitted_r, emitted_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0]     pend_sym_r, pend_sym_nxt;
  logic                 pend_fin_r, pend_fin_nxt;
  logic                 ov_r, ov_nxt;
  logic [SYM_W-1:0]     osym_r, osym_nxt;
  logic                 olast_r, olast_nxt;
  logic                 ofin_r, ofin_nxt;

  // one walk step
  logic                 active, bit_val, leaf, fin;
  logic [NODE_W-1:0]    moved;
  logic [CNT_W-1:0]     cnt_inc;

  assign active  = (emitted_r < cfg.total);
  assign bit_val = code_r[bit_idx_r];
  assign cnt_inc = emitted_r + 1'b1;
  assign fin     = (cnt_inc == cfg.total);
  assign leaf    = ~moved[NODE_W-1];

  always_comb begin
    moved = cur_r;
    if (cur_r[NODE_W-1]) begin
      if (bit_val) begin
        if (rdata_r[R_PRES_BIT]) moved = rdata_r[R_CHILD_LSB +: NODE_W];
      end else begin
        if (rdata_r[L_PRES_BIT]) moved = rdata_r[L_CHILD_LSB +: NODE_W];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_CODE) state_nxt = rd_ok_r ? ST_WALK : ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_WALK;
      ST_WALK: begin
        if (!active || bit_idx_r == '0 || (leaf && fin)) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cur_r[STORE_AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = q_item.addr;
    wr_data      = q_item.data;
    cur_nxt      = cur_r;
    rd_ok_nxt    = rd_ok_r;
    code_nxt     = code_r;
    bit_idx_nxt  = bit_idx_r;
    emitted_nxt  = emitted_r;
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    pend_fin_nxt = pend_fin_r;
    ov_nxt       = 1'b0;
    osym_nxt     = osym_r;
    olast_nxt    = olast_r;
    ofin_nxt     = ofin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_NODE) begin
            wr_en     = 1'b1;
            rd_ok_nxt = 1'b0;
          end else begin
            code_nxt    = q_item.data[CODE_W-1:0];
            bit_idx_nxt = BIT_IDX_W'(CODE_W - 1);
          end
        end
      end
      ST_LOAD: begin
        rd_en     = 1'b1;
        rd_ok_nxt = 1'b1;
      end
      ST_WALK: begin
        if (active) begin
          bit_idx_nxt = bit_idx_r - 1'b1;
          if (leaf) begin
            emitted_nxt = cnt_inc;
            if (pend_v_r) begin
              ov_nxt    = 1'b1;
              osym_nxt  = pend_sym_r;
              olast_nxt = 1'b0;
              ofin_nxt  = pend_fin_r;
            end
            pend_v_nxt   = 1'b1;
            pend_sym_nxt = moved[SYM_W-1:0];
            pend_fin_nxt = fin;
            cur_nxt      = cfg.root;
          end else begin
            cur_nxt = moved;
          end
          // keep rdata_r tracking the entry of the node walked next
          rd_en   = 1'b1;
          rd_addr = cur_nxt[STORE_AW-1:0];
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          ov_nxt    = 1'b1;
          osym_nxt  = pend_sym_r;
          olast_nxt = 1'b1;
          ofin_nxt  = pend_fin_r;
        end
        pend_v_nxt = 1'b0;
      end
      default: ;
    endcase
    if (cfg.root_wr) begin
      cur_nxt   = cfg.root_wdata;
      rd_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= NODE_W'(STORE_DEPTH);
      rd_ok_r   <= 1'b0;
      emitted_r <= '0;
      pend_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      rd_ok_r   <= rd_ok_nxt;
      emitted_r <= emitted_nxt;
      pend_v_r  <= pend_v_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    bit_idx_r  <= bit_idx_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_fin_r <= pend_fin_nxt;
    osym_r     <= osym_nxt;
    olast_r    <= olast_nxt;
    ofin_r     <= ofin_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= store_mem[rd_addr];
  end

  assign out_valid    = ov_r;
  assign out_symbol   = osym_r;
  assign out_last     = olast_r;
  assign out_finished = ofin_r;

endmodule
